// File: hw/rtl/ice_pkg.sv
// shared types and constants for the internet checksum engine
package ice_pkg;

    localparam int unsigned ACC_W = 18;

    localparam logic [15:0] OFFSET_LIMIT  = 16'hffff;
    localparam logic [5:0]  IP6_HDR_BYTES = 6'd40;
    localparam logic [15:0] UDP_MIN_COVER = 16'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  PROTO_ICMP6   = 8'd58;

    typedef enum logic [2:0] {
        MODE_IPV4_HDR = 3'd0,
        MODE_ICMP4    = 3'd1,
        MODE_UDP4     = 3'd2,
        MODE_UDP6     = 3'd3,
        MODE_ICMP6    = 3'd4
    } mode_t;

    // one classified byte on its way to the accumulator
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             mode_nz;
        logic [ACC_W-1:0] addend;
    } acc_req_t;

    // finished packet sum on its way to the output stage
    typedef struct packed {
        logic             valid;
        logic             mode_nz;
        logic [ACC_W-1:0] sum;
    } fin_req_t;

endpackage

// File: hw/rtl/internet_checksum_engine.sv
// top level of the internet checksum engine
//
// Streams packet bytes in network order, starting at the IP header, one byte per
// cycle, and returns one 16-bit ones' complement checksum for each request marked
// with tlast. checksum_mode picks the coverage: 0 IPv4 header, 1 ICMPv4 message,
// 2 UDP over IPv4, 3 UDP over IPv6, 4 ICMPv6 (other codes act as 0). Pseudoheader
// fields are picked out of the stream itself; bytes past the declared UDP or
// ICMPv6 length are ignored and a lone final byte is zero-padded. The pipeline
// is an input register, a classify stage, the accumulate stage and a fold/output
// register. A new byte is taken every cycle; the whole pipeline holds only while
// a checksum sits unclaimed in the output register. Write the mode only between
// packets.
module internet_checksum_engine
    import ice_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        checksum_mode_we,
    input  logic [2:0]  checksum_mode_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] checksum
);

    logic [2:0] mode_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    acc_req_t   acc_req;
    fin_req_t   fin_req;

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IPV4_HDR;
        end
        else if (checksum_mode_we)
        begin
            mode_reg <= checksum_mode_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ice_classify u_classify (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (in_valid_reg),
        .in_byte       (in_byte_reg),
        .in_last       (in_last_reg),
        .checksum_mode (mode_reg),
        .acc_req       (acc_req)
    );

    ice_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .acc_req (acc_req),
        .fin_req (fin_req)
    );

    ice_finish u_finish (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .fin_req  (fin_req),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

// File: hw/rtl/ice_classify.sv
// byte classifier: tracks packet offset and length fields, picks the word to add
module ice_classify
    import ice_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           in_valid,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    input  logic [2:0]     checksum_mode,
    output acc_req_t       acc_req
);

    logic [15:0] offset_reg;
    logic [5:0]  hdr_reg;
    logic [7:0]  pend_reg;
    logic [15:0] cov_reg;
    acc_req_t    acc_req_reg;

    mode_t       mode;
    logic        active;
    logic [5:0]  hdr_cur;
    logic [15:0] hdr_ext;
    logic [15:0] hdr_p4;
    logic [15:0] hdr_p5;
    logic        o_ge_h;
    logic [15:0] rel;
    logic        len_hi;
    logic        len_lo;
    logic [7:0]  pend_next;
    logic [15:0] cov_next;
    logic        in_pseudo;
    logic        in_region;
    logic [16:0] word;
    logic [ACC_W-1:0] base;
    logic [ACC_W-1:0] proto;
    logic        fire;

    always_comb
    begin
        if (checksum_mode > MODE_ICMP6)
        begin
            mode = MODE_IPV4_HDR;
        end
        else
        begin
            mode = mode_t'(checksum_mode);
        end

        active = offset_reg != OFFSET_LIMIT;

        // IPv4 header length is latched from the first byte of the packet; IPv6 modes use a fixed 40 bytes
        if (offset_reg == 16'd0)
        begin
            hdr_cur = (mode == MODE_UDP6 || mode == MODE_ICMP6) ? IP6_HDR_BYTES
                                                                : {in_byte[3:0], 2'b00};
        end
        else
        begin
            hdr_cur = hdr_reg;
        end

        hdr_ext = {10'd0, hdr_cur};
        hdr_p4  = hdr_ext + 16'd4;
        hdr_p5  = hdr_ext + 16'd5;
        o_ge_h  = offset_reg >= hdr_ext;
        rel     = offset_reg - hdr_ext;

        unique case (mode)
            MODE_UDP4, MODE_UDP6:
            begin
                len_hi = offset_reg == hdr_p4;
                len_lo = offset_reg == hdr_p5;
            end
            MODE_ICMP6:
            begin
                len_hi = offset_reg == 16'd4;
                len_lo = offset_reg == 16'd5;
            end
            default:
            begin
                len_hi = 1'b0;
                len_lo = 1'b0;
            end
        endcase

        pend_next = len_hi ? in_byte : pend_reg;
        cov_next  = len_lo ? {pend_reg, in_byte} : cov_reg;

        unique case (mode)
            MODE_UDP4:
            begin
                in_pseudo = offset_reg == 16'd9
                         || (offset_reg >= 16'd12 && offset_reg <= 16'd19)
                         || offset_reg == hdr_p4 || offset_reg == hdr_p5;
            end
            MODE_UDP6, MODE_ICMP6:
            begin
                in_pseudo = offset_reg == 16'd4 || offset_reg == 16'd5
                         || (offset_reg >= 16'd8 && offset_reg < {10'd0, IP6_HDR_BYTES});
            end
            default:
            begin
                in_pseudo = 1'b0;
            end
        endcase

        unique case (mode)
            MODE_IPV4_HDR: in_region = !o_ge_h;
            MODE_ICMP4:    in_region = o_ge_h;
            MODE_ICMP6:    in_region = o_ge_h && (rel < cov_next);
            default:       in_region = o_ge_h && (rel < UDP_MIN_COVER || rel < cov_next);
        endcase

        // even offsets are the high half of a word
        word = offset_reg[0] ? {9'd0, in_byte} : {1'b0, in_byte, 8'd0};

        if (active && in_pseudo && in_region)
        begin
            base = {word, 1'b0};
        end
        else if (active && (in_pseudo || in_region))
        begin
            base = {1'b0, word};
        end
        else
        begin
            base = '0;
        end

        if (in_last && mode == MODE_UDP6)
        begin
            proto = {{(ACC_W-8){1'b0}}, PROTO_UDP};
        end
        else if (in_last && mode == MODE_ICMP6)
        begin
            proto = {{(ACC_W-8){1'b0}}, PROTO_ICMP6};
        end
        else
        begin
            proto = '0;
        end

        fire = advance && in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            hdr_reg    <= '0;
            pend_reg   <= '0;
            cov_reg    <= '0;
        end
        else if (fire)
        begin
            if (in_last)
            begin
                offset_reg <= '0;
                hdr_reg    <= '0;
                pend_reg   <= '0;
                cov_reg    <= '0;
            end
            else if (active)
            begin
                offset_reg <= offset_reg + 16'd1;
                hdr_reg    <= hdr_cur;
                pend_reg   <= pend_next;
                cov_reg    <= cov_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_req_reg <= '0;
        end
        else if (advance)
        begin
            acc_req_reg.valid   <= in_valid;
            acc_req_reg.last    <= in_last;
            acc_req_reg.mode_nz <= mode != MODE_IPV4_HDR;
            acc_req_reg.addend  <= base + proto;
        end
    end

    assign acc_req = acc_req_reg;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last |=> offset_reg == 16'd0 && cov_reg == 16'd0)
        else $error("packet state not cleared after last byte");

    a_hdr_word_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_reg[1:0] == 2'b00)
        else $error("header length not a multiple of four");
`endif

endmodule

// File: hw/rtl/ice_accum.sv
// ones' complement accumulator with lazy carry fold
module ice_accum
    import ice_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  acc_req_t acc_req,
    output fin_req_t fin_req
);

    logic [ACC_W-1:0] acc_reg;
    fin_req_t         fin_req_reg;
    logic [ACC_W-1:0] sum;

    // top two bits wrap back in on the next add, so the value stays congruent mod 0xffff
    assign sum = {2'b00, acc_reg[15:0]} + {{(ACC_W-2){1'b0}}, acc_reg[ACC_W-1:16]}
               + acc_req.addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            fin_req_reg <= '0;
        end
        else if (advance)
        begin
            fin_req_reg.valid   <= acc_req.valid && acc_req.last;
            fin_req_reg.mode_nz <= acc_req.mode_nz;
            fin_req_reg.sum     <= sum;
            if (acc_req.valid)
            begin
                acc_reg <= acc_req.last ? '0 : sum;
            end
        end
    end

    assign fin_req = fin_req_reg;

`ifndef SYNTHESIS
    a_fin_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && acc_req.valid && acc_req.last |=> fin_req.valid && acc_reg == '0)
        else $error("last byte did not produce a finished sum");
`endif

endmodule

// File: hw/rtl/ice_finish.sv
// final carry fold, complement and output register
module ice_finish
    import ice_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  fin_req_t    fin_req,
    output logic        m_tvalid,
    output logic [15:0] m_tdata
);

    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] result;

    always_comb
    begin
        fold1  = {1'b0, fin_req.sum[15:0]} + {15'd0, fin_req.sum[ACC_W-1:16]};
        fold2  = fold1[15:0] + {15'd0, fold1[16]};
        result = ~fold2;
        // upper-layer checksums send zero as all ones
        if (fin_req.mode_nz && result == 16'd0)
        begin
            result = 16'hffff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m_tvalid_reg <= fin_req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_nonzero_upper: assert property (@(posedge clk) disable iff (!rst_n)
        advance && fin_req.valid && fin_req.mode_nz |=> m_tvalid && m_tdata != 16'd0)
        else $error("upper-layer checksum delivered as zero");
`endif

endmodule
